// ===== design/rc5_pkg.sv =====
// Shared definitions for the RC5 block encryptor: constants, codes and types.
// Depends on nothing; rc5_mix_unit and rc5_block_encryptor import it.
package rc5_pkg;

    // Default number of rounds and the magic constants of the key schedule.
    localparam int ROUNDS_DEFAULT = 12;
    localparam logic [31:0] MAGIC_P = 32'hB7E1_5163;
    localparam logic [31:0] MAGIC_Q = 32'h9E37_79B9;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd1;

    // Command codes carried on s_tuser.
    localparam logic CMD_EXPAND  = 1'b0;
    localparam logic CMD_ENCRYPT = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_MIX_RD,
        ST_MIX_A,
        ST_MIX_B,
        ST_ENC_RD,
        ST_ENC,
        ST_DONE
    } rc5_state_t;

    // Control of the shared mixing unit.
    typedef struct packed {
        logic       xor_mode;   // 1: combine with xor, 0: three-operand add
        logic [4:0] amount;     // left rotation amount
    } mix_op_t;

endpackage

// ===== design/rc5_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module rc5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 26
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/rc5_mix_unit.sv =====
// Shared RC5 arithmetic unit: combine, rotate left, add a round key.
// Depends on rc5_pkg for the operation struct.
module rc5_mix_unit
    import rc5_pkg::*;
(
    input  mix_op_t     op,
    input  logic [31:0] p,
    input  logic [31:0] q,
    input  logic [31:0] r,
    input  logic [31:0] k,
    output logic [31:0] y
);

    logic [31:0] combined;
    logic [63:0] doubled;
    logic [31:0] rotated;

    // Either p ^ q, or the three-operand sum p + q + r (modulo 2^32).
    always_comb begin
        if (op.xor_mode) begin
            combined = p ^ q;
        end else begin
            combined = p + q + r;
        end
    end

    // Rotation through a doubled word; an amount of zero leaves the word as it is.
    assign doubled = {combined, combined} << op.amount;
    assign rotated = doubled[63:32];
    assign y       = rotated + k;

endmodule

// ===== design/rc5_block_encryptor.sv =====
// Top level of the RC5-32 block encryptor: sequencer, key registers and round-key table.
// Depends on rc5_pkg, rc5_ram and rc5_mix_unit.
//
// Usage:
// - Key: write key_low (index 0) and key_high (index 1) on the cfg channel while idle.
// - Input channel s_*: s_tuser carries the command (0 expands the key, 1 encrypts),
//   s_tdata carries the two plaintext words.
// - Result channel m_*: one transaction per input transaction, holding the two cipher
//   words, or zeros after a key expansion.
// - An encryption makes one table read to start, then one half-round per cycle through
//   the single mixing unit, paced by the one read port of the round-key table.
// - A key expansion runs a table fill of one word a cycle, then each of the
//   6*(ROUNDS+1) mixing steps takes two passes through the unit.
// - One item is processed at a time; s_tready is high only while the sequencer idles.
// - The result sits in an output register, so the next item is accepted while it waits;
//   if that item finishes before the result is taken, it holds until m_tready.
// - Reset clears the key registers, and the round-key table reads as zeros until the
//   first key expansion fills it.
module rc5_block_encryptor
    import rc5_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,   // word_a [31:0], word_b [63:32]
    input  logic                   s_tuser,   // cmd [0]
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [63:0]            m_tdata    // cipher_a [31:0], cipher_b [63:32]
);

    localparam int TABLE_WORDS = 2 * (ROUNDS + 1);
    localparam int MIX_STEPS   = 3 * TABLE_WORDS;
    localparam int IDX_W       = $clog2(TABLE_WORDS);
    localparam int STEP_W      = $clog2(MIX_STEPS);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_WORDS - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MIX_STEPS - 1);

    rc5_state_t state_reg, state_next;

    logic [63:0]      key_low_reg;
    logic [63:0]      key_high_reg;
    logic             table_valid_reg;
    logic             m_valid_reg;
    logic [31:0]      out_a_reg;
    logic [31:0]      out_b_reg;
    logic             cmd_reg;
    logic [31:0]      a_reg;
    logic [31:0]      b_reg;
    logic [31:0]      kw_reg [4];
    logic [1:0]       u_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [STEP_W-1:0] step_reg;

    logic             s_accept;
    logic             out_free;
    logic [IDX_W-1:0] idx_wrap;
    logic             first_pair;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [31:0]      ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [31:0]      ram_rdata;
    logic [31:0]      round_key;

    mix_op_t          mix_op;
    logic [31:0]      mix_p;
    logic [31:0]      mix_q;
    logic [31:0]      mix_r;
    logic [31:0]      mix_k;
    logic [31:0]      mix_y;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {out_b_reg, out_a_reg};

    assign idx_wrap   = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign first_pair = (idx_reg[IDX_W-1:1] == '0);

    // The table reads as zeros until the first expansion has filled it.
    assign round_key = table_valid_reg ? ram_rdata : 32'd0;

    rc5_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_WORDS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rc5_mix_unit u_mix (
        .op (mix_op),
        .p  (mix_p),
        .q  (mix_q),
        .r  (mix_r),
        .k  (mix_k),
        .y  (mix_y)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser == CMD_ENCRYPT) ? ST_ENC_RD : ST_FILL;
                end
            end
            ST_FILL: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_MIX_RD;
                end
            end
            ST_MIX_RD: state_next = ST_MIX_A;
            ST_MIX_A:  state_next = ST_MIX_B;
            ST_MIX_B: begin
                state_next = (step_reg == LAST_STEP) ? ST_DONE : ST_MIX_A;
            end
            ST_ENC_RD: state_next = ST_ENC;
            ST_ENC: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Table port and mixing-unit operands for each state.
    always_comb begin
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = mix_y;
        ram_raddr     = idx_reg;
        mix_op.xor_mode = 1'b0;
        mix_op.amount   = 5'd0;
        mix_p         = a_reg;
        mix_q         = 32'd0;
        mix_r         = 32'd0;
        mix_k         = 32'd0;
        unique case (state_reg)
            ST_FILL: begin
                // The current word is written while the unit steps it on by Q.
                ram_we    = 1'b1;
                ram_wdata = a_reg;
                mix_q     = MAGIC_Q;
            end
            ST_MIX_A: begin
                // A = rotl(S[t] + A + B, 3), written back to the table.
                ram_we        = 1'b1;
                mix_p         = round_key;
                mix_q         = a_reg;
                mix_r         = b_reg;
                mix_op.amount = 5'd3;
            end
            ST_MIX_B: begin
                // B = rotl(L[u] + A + B, A + B); fetch the next table word meanwhile.
                mix_p         = kw_reg[u_reg];
                mix_q         = a_reg;
                mix_r         = b_reg;
                mix_op.amount = a_reg[4:0] + b_reg[4:0];
                ram_raddr     = idx_wrap;
            end
            ST_ENC: begin
                ram_raddr = idx_wrap;
                mix_k     = round_key;
                if (first_pair) begin
                    // Whitening: plain add of the first two round keys.
                    mix_p = idx_reg[0] ? b_reg : a_reg;
                end else if (!idx_reg[0]) begin
                    mix_op.xor_mode = 1'b1;
                    mix_op.amount   = b_reg[4:0];
                    mix_p           = a_reg;
                    mix_q           = b_reg;
                end else begin
                    mix_op.xor_mode = 1'b1;
                    mix_op.amount   = a_reg[4:0];
                    mix_p           = b_reg;
                    mix_q           = a_reg;
                end
            end
            ST_IDLE, ST_MIX_RD, ST_ENC_RD, ST_DONE: begin
                ram_raddr = '0;
            end
            default: begin
                ram_raddr = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            key_low_reg     <= 64'd0;
            key_high_reg    <= 64'd0;
            table_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_KEY_LOW) begin
                    key_low_reg <= cfg_data;
                end else if (cfg_index == REG_KEY_HIGH) begin
                    key_high_reg <= cfg_data;
                end
            end
            if (state_reg == ST_FILL && idx_reg == LAST_IDX) begin
                table_valid_reg <= 1'b1;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd_reg  <= s_tuser;
                    idx_reg  <= '0;
                    step_reg <= '0;
                    u_reg    <= 2'd0;
                    if (s_tuser == CMD_ENCRYPT) begin
                        a_reg <= s_tdata[31:0];
                        b_reg <= s_tdata[63:32];
                    end else begin
                        a_reg     <= MAGIC_P;
                        kw_reg[0] <= key_low_reg[31:0];
                        kw_reg[1] <= key_low_reg[63:32];
                        kw_reg[2] <= key_high_reg[31:0];
                        kw_reg[3] <= key_high_reg[63:32];
                    end
                end
            end
            ST_FILL: begin
                idx_reg <= idx_wrap;
                if (idx_reg == LAST_IDX) begin
                    a_reg <= 32'd0;
                    b_reg <= 32'd0;
                end else begin
                    a_reg <= mix_y;
                end
            end
            ST_MIX_A: begin
                a_reg <= mix_y;
            end
            ST_MIX_B: begin
                b_reg         <= mix_y;
                kw_reg[u_reg] <= mix_y;
                u_reg         <= u_reg + 2'd1;
                idx_reg       <= idx_wrap;
                step_reg      <= step_reg + 1'b1;
            end
            ST_ENC: begin
                idx_reg <= idx_wrap;
                if (idx_reg[0]) begin
                    b_reg <= mix_y;
                end else begin
                    a_reg <= mix_y;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_a_reg <= (cmd_reg == CMD_ENCRYPT) ? a_reg : 32'd0;
                    out_b_reg <= (cmd_reg == CMD_ENCRYPT) ? b_reg : 32'd0;
                end
            end
            ST_MIX_RD, ST_ENC_RD: begin
            end
            default: begin
            end
        endcase
    end

endmodule
